FILE: hdl/sspq_pkg.sv
package sspq_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int PRI_W    = 8;
  localparam int TAG_W    = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  // operation kinds (input tuser)
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // result status codes (output tuser)
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [PRI_W-1:0] pri;
    logic [TAG_W-1:0] tag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: hdl/stable_sorted_priority_queue_core.sv
// Pop: POP_RD reads the head slot and POP_DAT takes its data. Push: the hole rises
// past each lower-priority entry (one RAM read and one priority compare per shifted
// entry), then takes the new entry; push on full or pop on empty goes straight to
// OUT. One operation at a time; the next is taken once the sequencer is back in
// idle, even while the previous result still waits in the output register. rst
// (synchronous) empties the queue and clears control; RAM contents are left as is.
module stable_sorted_priority_queue_core
  import sspq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [7:0] priority_req, [39:8] payload_tag
  input  logic [0:0]  s_axis_tuser,   // [0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [7:0] out_priority, [39:8] out_payload,
                                      // [44:40] occupancy, [47:45] zero
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [PTR_W:0]   SUM_WRAP = (PTR_W + 1)'(DEPTH);

  // sequencer states
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_PUSH_RD  = 3'd1;
  localparam logic [2:0] S_PUSH_CMP = 3'd2;
  localparam logic [2:0] S_POP_RD   = 3'd3;
  localparam logic [2:0] S_POP_DAT  = 3'd4;
  localparam logic [2:0] S_OUT      = 3'd5;

  logic [2:0]       state, state_next;
  logic [CNT_W-1:0] count, count_next;      // stored entries
  logic [PTR_W-1:0] head, head_next;        // physical slot of the top entry
  logic [PTR_W-1:0] hole, hole_next;        // slot being filled during a push
  logic [CNT_W-1:0] hole_pos, hole_pos_next; // logical position of the hole

  entry_t           op_entry;               // transaction being worked on
  logic [STATUS_W-1:0] res_status, res_status_next;
  entry_t           res_entry, res_entry_next;

  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  entry_t              out_entry;
  logic [OCC_W-1:0]    out_occ;

  logic             ram_we;
  logic [PTR_W-1:0] ram_waddr, ram_raddr;
  entry_t           ram_wdata, ram_rdata;

  logic [PTR_W:0]   tail_sum;
  logic [PTR_W-1:0] tail, hole_prev;
  logic             in_fire, out_load;

  sspq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign s_axis_tready = (state == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state == S_OUT) && (!out_valid || m_axis_tready);

  // circular buffer: tail slot = head + count (wraps at DEPTH)
  assign tail_sum  = {1'b0, head} + {1'b0, count[PTR_W-1:0]};
  assign tail      = (tail_sum >= SUM_WRAP) ? PTR_W'(tail_sum - SUM_WRAP)
                                            : tail_sum[PTR_W-1:0];
  assign hole_prev = (hole == '0) ? PTR_LAST : hole - 1'b1;

  always_comb begin
    state_next      = state;
    count_next      = count;
    head_next       = head;
    hole_next       = hole;
    hole_pos_next   = hole_pos;
    res_status_next = res_status;
    res_entry_next  = res_entry;
    ram_we          = 1'b0;
    ram_waddr       = hole;
    ram_wdata       = op_entry;
    ram_raddr       = (state == S_POP_RD) ? head : hole_prev;

    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          res_status_next = ST_OK;
          res_entry_next  = '0;
          if (s_axis_tuser[0] == OP_PUSH) begin
            if (count == CNT_FULL) begin
              res_status_next = ST_FULL;
              state_next      = S_OUT;
            end else begin
              hole_next     = tail;
              hole_pos_next = count;
              state_next    = S_PUSH_RD;
            end
          end else begin
            if (count == '0) begin
              res_status_next = ST_EMPTY;
              state_next      = S_OUT;
            end else begin
              state_next = S_POP_RD;
            end
          end
        end
      end
      S_PUSH_RD: begin
        // hole at the top: nothing above to compare
        if (hole_pos == '0) begin
          ram_we     = 1'b1;
          count_next = count + 1'b1;
          state_next = S_OUT;
        end else begin
          state_next = S_PUSH_CMP;
        end
      end
      S_PUSH_CMP: begin
        // entry above the hole: move it down if strictly lower priority
        if (ram_rdata.pri < op_entry.pri) begin
          ram_we        = 1'b1;
          ram_wdata     = ram_rdata;
          hole_next     = hole_prev;
          hole_pos_next = hole_pos - 1'b1;
          state_next    = S_PUSH_RD;
        end else begin
          ram_we     = 1'b1;
          count_next = count + 1'b1;
          state_next = S_OUT;
        end
      end
      S_POP_RD: begin
        state_next = S_POP_DAT;
      end
      S_POP_DAT: begin
        res_entry_next = ram_rdata;
        head_next      = (head == PTR_LAST) ? '0 : head + 1'b1;
        count_next     = count - 1'b1;
        state_next     = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      head      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      head  <= head_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    hole       <= hole_next;
    hole_pos   <= hole_pos_next;
    res_status <= res_status_next;
    res_entry  <= res_entry_next;
    if (in_fire) begin
      op_entry.pri <= s_axis_tdata[7:0];
      op_entry.tag <= s_axis_tdata[39:8];
    end
    if (out_load) begin
      out_status <= res_status;
      out_entry  <= res_entry;
      out_occ    <= OCC_W'(count);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_status;
  assign m_axis_tdata  = {3'b000, out_occ, out_entry.tag, out_entry.pri};

  // ---------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("entry count above capacity");

  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status == ST_FULL) |-> out_occ == OCC_W'(DEPTH))
    else $error("full drop reported with queue not full");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status == ST_EMPTY) |->
      (out_entry == '0) && (out_occ == '0))
    else $error("empty pop result not zero");

  a_load_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state) == S_OUT)
    else $error("result shown outside the output step");

  a_write_in_push: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_PUSH_RD) || (state == S_PUSH_CMP))
    else $error("RAM written outside a push");

endmodule

FILE: hdl/sspq_ram.sv
module sspq_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: test/stable_sorted_priority_queue_core_tb.sv
`timescale 1ns / 100ps

module stable_sorted_priority_queue_core_tb;
  import sspq_pkg::*;

  localparam int QDEPTH    = DEPTH_DEF;
  localparam int N_RANDOM  = 1200;
  localparam int PHASE_LEN = 300;   // operations per idling phase
  localparam int QUIET_MAX = 2000;  // cycles with no transaction before giving up
  localparam int DRAIN_GAP = 40;    // wait after the last reply, in cycles
  localparam int HOLD_LEN  = 300;   // long sink hold-off, in cycles
  localparam int HOLD_AT_A = 60;
  localparam int HOLD_AT_B = 170;

  // idling phases, in order of operation index
  typedef enum logic [1:0] {PH_STEADY, PH_SRC_GAPS, PH_SINK_STALLS, PH_BOTH} phase_t;
  // random traffic mixes
  typedef enum logic [1:0] {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  typedef struct packed {
    logic             kind;
    logic [PRI_W-1:0] pri;
    logic [TAG_W-1:0] tag;
    phase_t           phase;
  } op_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PRI_W-1:0]    pri;
    logic [TAG_W-1:0]    tag;
    logic [OCC_W-1:0]    occ;
    phase_t              phase;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  stable_sorted_priority_queue_core #(.DEPTH(QDEPTH)) u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] priority_req, [39:8] payload_tag
    .s_axis_tuser  (s_axis_tuser),   // [0] kind
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [7:0] out_priority, [39:8] out_payload,
                                     // [44:40] occupancy, [47:45] zero
    .m_axis_tuser  (m_axis_tuser)    // [1:0] status
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the sorted queue: index 0 is the head (highest priority).
  // ---------------------------------------------------------------------------
  logic [PRI_W-1:0] shadow_pri [QDEPTH];
  logic [TAG_W-1:0] shadow_tag [QDEPTH];
  int               shadow_count = 0;

  op_item_t pending_ops[$];     // operations not yet taken by the block
  reply_t   awaited_replies[$]; // predicted replies, oldest first

  int errors     = 0;
  int n_replies  = 0;
  int n_dropped  = 0;
  int n_empty    = 0;
  int n_push     = 0;
  int n_pop      = 0;
  int hold_left  = 0;
  int quiet      = 0;
  phase_t sink_phase = PH_STEADY;

  // Applies one operation to the shadow queue and returns the reply it earns.
  function automatic reply_t queue_apply(input op_item_t op);
    reply_t r;
    int     pos;
    r        = '0;
    r.status = ST_OK;
    r.phase  = op.phase;
    if (op.kind == OP_PUSH) begin
      if (shadow_count >= QDEPTH) begin
        r.status = ST_FULL;
      end else begin
        // new entry goes behind every entry of equal or higher priority
        pos = 0;
        while (pos < shadow_count && shadow_pri[pos] >= op.pri) pos++;
        for (int i = shadow_count; i > pos; i--) begin
          shadow_pri[i] = shadow_pri[i-1];
          shadow_tag[i] = shadow_tag[i-1];
        end
        shadow_pri[pos] = op.pri;
        shadow_tag[pos] = op.tag;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.pri = shadow_pri[0];
      r.tag = shadow_tag[0];
      for (int i = 1; i < shadow_count; i++) begin
        shadow_pri[i-1] = shadow_pri[i];
        shadow_tag[i-1] = shadow_tag[i];
      end
      shadow_count--;
    end
    r.occ = OCC_W'(shadow_count);
    return r;
  endfunction

  task automatic add_op(input logic kind, input logic [PRI_W-1:0] pri,
                        input logic [TAG_W-1:0] tag);
    op_item_t op;
    op.kind  = kind;
    op.pri   = pri;
    op.tag   = tag;
    op.phase = phase_t'((pending_ops.size() / PHASE_LEN) % 4);
    pending_ops.push_back(op);
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers the head of pending_ops; a transaction fires when
  // tvalid and tready are both high at the edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    op_item_t nxt;
    reply_t   r;
    int       gap_pct;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        nxt = pending_ops.pop_front();
        r = queue_apply(nxt);
        awaited_replies.push_back(r);
        if (nxt.kind == OP_PUSH) n_push++;
        else n_pop++;
      end
      // hold tvalid steady until the pending transaction completes
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_ops.size() > 0) begin
          nxt = pending_ops[0];
          gap_pct = (nxt.phase == PH_SRC_GAPS) ? 48 : (nxt.phase == PH_BOTH) ? 34 : 0;
        end
        if (pending_ops.size() > 0 && $urandom_range(99) >= gap_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {nxt.tag, nxt.pri};
          s_axis_tuser  <= nxt.kind;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks every reply against the oldest prediction and drives
  // m_axis_tready, including the long hold-off that backs up the block.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    reply_t want;
    int     stall_pct;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_replies++;
        if (m_axis_tuser == ST_FULL) n_dropped++;
        if (m_axis_tuser == ST_EMPTY) n_empty++;
        if (awaited_replies.size() == 0) begin
          errors++;
          $display("%0t: unexpected reply, expected none, actual status %h data %h",
                   $time, m_axis_tuser, m_axis_tdata);
        end else begin
          want = awaited_replies.pop_front();
          sink_phase = want.phase;
          check_field("status", 32'(want.status), 32'(m_axis_tuser));
          check_field("out_priority", 32'(want.pri), 32'(m_axis_tdata[7:0]));
          check_field("out_payload", want.tag, m_axis_tdata[39:8]);
          check_field("occupancy", 32'(want.occ), 32'(m_axis_tdata[44:40]));
          check_field("pad bits", 32'd0, 32'(m_axis_tdata[47:45]));
        end
        if (n_replies == HOLD_AT_A || n_replies == HOLD_AT_B) hold_left = HOLD_LEN;
      end
      if (awaited_replies.size() > 0) sink_phase = awaited_replies[0].phase;
      stall_pct = (sink_phase == PH_SINK_STALLS) ? 48 : (sink_phase == PH_BOTH) ? 34 : 0;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // watchdog: too long without any transaction on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_MAX) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    mix_t             mix;
    int               seg_len;
    int               push_pct;
    int               pri_lo;
    int               pri_mode;
    int               n_rand;
    logic             kind;
    logic [PRI_W-1:0] pri;

    // directed: pop on empty, extremes, equal priorities keep arrival order
    add_op(OP_POP,  8'd0,   32'h0);
    add_op(OP_PUSH, 8'd0,   32'h0000_0000);
    add_op(OP_PUSH, 8'd255, 32'hFFFF_FFFF);
    add_op(OP_PUSH, 8'd128, 32'hAAAA_5555);
    add_op(OP_PUSH, 8'd128, 32'h5555_AAAA);
    add_op(OP_PUSH, 8'd255, 32'h1234_5678);
    add_op(OP_PUSH, 8'd0,   32'h8765_4321);
    repeat (7) add_op(OP_POP, 8'hFF, 32'hFFFF_FFFF);
    // fill to capacity with ties, then push on full
    for (int i = 0; i < QDEPTH + 2; i++) add_op(OP_PUSH, 8'(i % 3), $urandom);
    add_op(OP_POP, 8'd0, 32'h0);
    add_op(OP_PUSH, 8'd1, 32'hC0DE_0001);

    // random: segments that fill, drain or hover, tie-heavy or wide priorities
    n_rand = 0;
    while (n_rand < N_RANDOM) begin
      mix      = mix_t'($urandom_range(2));
      seg_len  = $urandom_range(10, 60);
      push_pct = (mix == MIX_FILL) ? 85 : (mix == MIX_DRAIN) ? 15 : 50;
      pri_mode = $urandom_range(2);
      pri_lo   = $urandom_range(252);
      for (int k = 0; k < seg_len; k++) begin
        kind = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
        case (pri_mode)
          0:       pri = 8'($urandom_range(pri_lo + 3, pri_lo));
          1:       pri = 8'($urandom_range(255));
          default: pri = $urandom_range(1) ? 8'd255 : 8'd0;
        endcase
        add_op(kind, pri, $urandom);
        n_rand++;
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    wait (pending_ops.size() == 0 && awaited_replies.size() == 0);
    repeat (DRAIN_GAP) @(posedge clk);

    $display("Ran %0d operations (%0d push, %0d pop) through four idling phases",
             n_push + n_pop, n_push, n_pop);
    $display("with %0d pushes dropped on full and %0d pops on empty",
             n_dropped, n_empty);
    if (errors == 0 && awaited_replies.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
